@@ src/fnbc_pkg.sv @@
// fnbc_pkg: shared constants and types for the face normal / backface cull core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fnbc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORM_W          = 30;   // normalised magnitude width
    localparam int FRAC_W          = 14;   // q1.14 fraction bits
    localparam int QUO_W           = 15;   // normal magnitude width, up to 16384
    localparam int OUT_W           = 16;
    localparam int EPS_W           = 15;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CULL_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CULL_EPSILON = 1'b1;

    // side information that rides along with each transaction
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
        logic       dbl;
    } t_side;

endpackage

`default_nettype wire

@@ src/face_normal_backface_cull_core.sv @@
// face_normal_backface_cull_core: unit face normal and backface cull decision
// depends on: fnbc_pkg, fnbc_isqrt, fnbc_div
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | v0..v2 xyz, double_sided
//  out     | output    | o_out_valid / i_out_ready   | normal xyz, culled, degenerate
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_wdata
//
// one transaction per cycle while no result waits at the output; the pipeline holds
// nine front stages, the 31-stage square root, the 16-stage divider
// and an output register. the whole pipeline advances together and holds while
// a result waits; the input stage still fills if it is empty.
// synchronous active-low reset clears valid bits and sets the configuration registers to cull enabled, epsilon 1.
`timescale 1ns / 1ps
`default_nettype none

module face_normal_backface_cull_core #(
    parameter int COORD_WIDTH = fnbc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v0_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v0_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v0_z,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v1_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v1_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v1_z,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v2_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v2_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_v2_z,
    input  wire logic                              i_double_sided,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [fnbc_pkg::OUT_W-1:0]      o_normal_x,
    output logic signed [fnbc_pkg::OUT_W-1:0]      o_normal_y,
    output logic signed [fnbc_pkg::OUT_W-1:0]      o_normal_z,
    output logic                                   o_culled,
    output logic                                   o_degenerate,
    input  wire logic                              i_cfg_we,
    input  wire logic [fnbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fnbc_pkg::EPS_W-1:0]        i_cfg_wdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = (CW > 30) ? 31 : CW + 1;
    localparam int SH   = (CW > 30) ? CW - 30 : 0;
    localparam int MW   = 2 * DW;
    localparam int CPW  = MW + 1;
    localparam int NCH  = (MW + 7) / 8;
    localparam int BW   = $clog2(MW + 1);
    localparam int NW   = fnbc_pkg::NORM_W;
    localparam int SQW  = 2 * NW + 2;
    localparam int LW   = SQW / 2;
    localparam int QW   = fnbc_pkg::QUO_W;
    localparam int OW   = fnbc_pkg::OUT_W;
    localparam int EW   = fnbc_pkg::EPS_W;
    localparam int SW   = 3 * NW + $bits(fnbc_pkg::t_side);
    localparam int NST  = 9 + LW + QW + 1 + 1;

    // ---------------- configuration ----------------
    logic          r_cull_enable;
    logic [EW-1:0] r_cull_epsilon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_enable  <= 1'b1;
            r_cull_epsilon <= EW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fnbc_pkg::CFG_CULL_ENABLE:  r_cull_enable  <= i_cfg_wdata[0];
                fnbc_pkg::CFG_CULL_EPSILON: r_cull_epsilon <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic           w_en;
    logic           w_en0;
    logic [NST-1:0] r_vld;

    assign w_en       = !r_vld[NST-1] || i_out_ready;
    assign w_en0      = w_en || !r_vld[0];
    assign o_in_ready = w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en0) begin
                r_vld[0] <= i_in_valid;
            end
            if (w_en) begin
                r_vld[NST-1:1] <= r_vld[NST-2:0];
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    logic signed [CW-1:0] r_v0 [3];
    logic signed [CW-1:0] r_v1 [3];
    logic signed [CW-1:0] r_v2 [3];
    logic                 r_s0_dbl;

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_v0[0] <= i_v0_x;  r_v0[1] <= i_v0_y;  r_v0[2] <= i_v0_z;
            r_v1[0] <= i_v1_x;  r_v1[1] <= i_v1_y;  r_v1[2] <= i_v1_z;
            r_v2[0] <= i_v2_x;  r_v2[1] <= i_v2_y;  r_v2[2] <= i_v2_z;
            r_s0_dbl <= i_double_sided;
        end
    end

    // ---------------- stage 1: edge vectors ----------------
    logic signed [DW-1:0] n_d1 [3];
    logic signed [DW-1:0] n_d2 [3];
    logic signed [DW-1:0] r_d1 [3];
    logic signed [DW-1:0] r_d2 [3];
    logic                 r_s1_dbl;

    for (genvar i = 0; i < 3; i++) begin : g_edge
        logic signed [CW:0] w_e1;
        logic signed [CW:0] w_e2;

        assign w_e1 = {r_v1[i][CW-1], r_v1[i]} - {r_v0[i][CW-1], r_v0[i]};
        assign w_e2 = {r_v2[i][CW-1], r_v2[i]} - {r_v1[i][CW-1], r_v1[i]};

        if (SH > 0) begin : g_scale
            // bias negatives so the arithmetic shift truncates toward zero
            logic signed [CW:0] w_b1;
            logic signed [CW:0] w_b2;
            logic signed [CW:0] w_t1;
            logic signed [CW:0] w_t2;

            assign w_b1 = w_e1[CW] ? (CW+1)'((1 << SH) - 1) : '0;
            assign w_b2 = w_e2[CW] ? (CW+1)'((1 << SH) - 1) : '0;
            assign w_t1 = (w_e1 + w_b1) >>> SH;
            assign w_t2 = (w_e2 + w_b2) >>> SH;
            assign n_d1[i] = w_t1[DW-1:0];
            assign n_d2[i] = w_t2[DW-1:0];
        end else begin : g_exact
            assign n_d1[i] = w_e1[DW-1:0];
            assign n_d2[i] = w_e2[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1     <= n_d1;
            r_d2     <= n_d2;
            r_s1_dbl <= r_s0_dbl;
        end
    end

    // ---------------- stage 2: partial products ----------------
    logic signed [MW-1:0] r_p [6];
    logic                 r_s2_dbl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0]   <= r_d1[1] * r_d2[2];
            r_p[1]   <= r_d1[2] * r_d2[1];
            r_p[2]   <= r_d1[2] * r_d2[0];
            r_p[3]   <= r_d1[0] * r_d2[2];
            r_p[4]   <= r_d1[0] * r_d2[1];
            r_p[5]   <= r_d1[1] * r_d2[0];
            r_s2_dbl <= r_s1_dbl;
        end
    end

    // ---------------- stage 3: cross product, sign and magnitude ----------------
    logic [MW-1:0] n_mag [3];
    logic [2:0]    n_neg;
    logic [MW-1:0] r_s3_mag [3];
    logic [2:0]    r_s3_neg;
    logic          r_s3_dbl;

    for (genvar i = 0; i < 3; i++) begin : g_cross
        logic signed [CPW-1:0] w_c;
        logic        [CPW-1:0] w_nc;

        assign w_c      = {r_p[2*i][MW-1], r_p[2*i]} - {r_p[2*i+1][MW-1], r_p[2*i+1]};
        assign w_nc     = -w_c;
        assign n_neg[i] = w_c[CPW-1];
        assign n_mag[i] = w_c[CPW-1] ? w_nc[MW-1:0] : w_c[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_mag <= n_mag;
            r_s3_neg <= n_neg;
            r_s3_dbl <= r_s2_dbl;
        end
    end

    // ---------------- stage 4: per-byte leading one search ----------------
    logic [NCH*8-1:0] w_or;
    logic [NCH-1:0]   n_nz;
    logic [3:0]       n_lb [NCH];
    logic [MW-1:0]    r_s4_mag [3];
    logic [2:0]       r_s4_neg;
    logic             r_s4_dbl;
    logic [NCH-1:0]   r_nz;
    logic [3:0]       r_lb [NCH];

    // bit length of the largest magnitude equals that of the or of all three
    assign w_or = (NCH*8)'(r_s3_mag[0] | r_s3_mag[1] | r_s3_mag[2]);

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            n_nz[j] = |w_or[j*8 +: 8];
            n_lb[j] = '0;
            for (int k = 0; k < 8; k++) begin
                if (w_or[j*8+k]) begin
                    n_lb[j] = 4'(k + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_mag <= r_s3_mag;
            r_s4_neg <= r_s3_neg;
            r_s4_dbl <= r_s3_dbl;
            r_nz     <= n_nz;
            r_lb     <= n_lb;
        end
    end

    // ---------------- stage 5: bit length ----------------
    logic [BW-1:0] n_b;
    logic [BW-1:0] r_b;
    logic [MW-1:0] r_s5_mag [3];
    logic [2:0]    r_s5_neg;
    logic          r_s5_dbl;
    logic          r_s5_degen;

    always_comb begin
        n_b = '0;
        for (int j = 0; j < NCH; j++) begin
            if (r_nz[j]) begin
                n_b = BW'(j * 8) + BW'(r_lb[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b        <= n_b;
            r_s5_mag   <= r_s4_mag;
            r_s5_neg   <= r_s4_neg;
            r_s5_dbl   <= r_s4_dbl;
            r_s5_degen <= ~|r_nz;
        end
    end

    // ---------------- stage 6: normalise to 30 bits ----------------
    logic [NW-1:0] n_sm [3];
    logic [NW-1:0] r_sm [3];
    logic [2:0]    r_s6_neg;
    logic          r_s6_dbl;
    logic          r_s6_degen;

    // (mag << 30) >> b gives the left or the truncating right shift in one go
    for (genvar i = 0; i < 3; i++) begin : g_norm
        logic [MW+NW-1:0] w_ext;

        assign w_ext   = {r_s5_mag[i], {NW{1'b0}}} >> r_b;
        assign n_sm[i] = w_ext[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sm       <= n_sm;
            r_s6_neg   <= r_s5_neg;
            r_s6_dbl   <= r_s5_dbl;
            r_s6_degen <= r_s5_degen;
        end
    end

    // ---------------- stage 7: squares ----------------
    logic [2*NW-1:0] r_sq [3];
    logic [NW-1:0]   r_s7_sm [3];
    logic [2:0]      r_s7_neg;
    logic            r_s7_dbl;
    logic            r_s7_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_sm[i] * r_sm[i];
            end
            r_s7_sm    <= r_sm;
            r_s7_neg   <= r_s6_neg;
            r_s7_dbl   <= r_s6_dbl;
            r_s7_degen <= r_s6_degen;
        end
    end

    // ---------------- stage 8: sum of squares ----------------
    logic [SQW-1:0]  r_sum;
    logic [NW-1:0]   r_s8_sm [3];
    fnbc_pkg::t_side r_s8_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum           <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
            r_s8_sm         <= r_s7_sm;
            r_s8_side.neg   <= r_s7_neg;
            r_s8_side.degen <= r_s7_degen;
            r_s8_side.dbl   <= r_s7_dbl;
        end
    end

    // ---------------- square root ----------------
    logic [SW-1:0]   w_sq_side_in;
    logic [SW-1:0]   w_sq_side_out;
    logic [LW-1:0]   w_len;

    assign w_sq_side_in = {r_s8_sm[2], r_s8_sm[1], r_s8_sm[0], r_s8_side};

    fnbc_isqrt #(
        .XW (SQW),
        .SW (SW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_sum),
        .i_side (w_sq_side_in),
        .o_root (w_len),
        .o_side (w_sq_side_out)
    );

    // ---------------- division ----------------
    logic [2:0][NW-1:0] w_div_mag;
    fnbc_pkg::t_side    w_div_side_in;
    logic [2:0][QW-1:0] w_quo;
    fnbc_pkg::t_side    w_div_side;

    assign w_div_mag     = w_sq_side_out[SW-1:$bits(fnbc_pkg::t_side)];
    assign w_div_side_in = w_sq_side_out[$bits(fnbc_pkg::t_side)-1:0];

    fnbc_div #(
        .MAG_W (NW),
        .LEN_W (LW)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (w_div_mag),
        .i_len  (w_len),
        .i_side (w_div_side_in),
        .o_quo  (w_quo),
        .o_side (w_div_side)
    );

    // ---------------- output stage ----------------
    logic signed [OW-1:0] n_n [3];
    logic signed [OW:0]   w_nz_ext;
    logic signed [OW:0]   w_neg_eps;
    logic                 n_culled;
    logic signed [OW-1:0] r_n [3];
    logic                 r_culled;
    logic                 r_degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_div_side.degen) begin
                n_n[i] = '0;
            end else if (w_div_side.neg[i]) begin
                n_n[i] = -OW'(w_quo[i]);
            end else begin
                n_n[i] = OW'(w_quo[i]);
            end
        end
    end

    assign w_nz_ext  = {n_n[2][OW-1], n_n[2]};
    assign w_neg_eps = -$signed({{(OW+1-EW){1'b0}}, r_cull_epsilon});
    assign n_culled  = r_cull_enable && !w_div_side.dbl && !w_div_side.degen &&
                       (w_nz_ext < w_neg_eps);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n      <= n_n;
            r_culled <= n_culled;
            r_degen  <= w_div_side.degen;
        end
    end

    assign o_out_valid  = r_vld[NST-1];
    assign o_normal_x   = r_n[0];
    assign o_normal_y   = r_n[1];
    assign o_normal_z   = r_n[2];
    assign o_culled     = r_culled;
    assign o_degenerate = r_degen;

endmodule

`default_nettype wire

@@ src/fnbc_isqrt.sv @@
// fnbc_isqrt: pipelined integer square root, one root bit per stage
// depends on: nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module fnbc_isqrt #(
    parameter int XW = 62,
    parameter int SW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW-1:0]     i_x,
    input  wire logic [SW-1:0]     i_side,
    output logic      [XW/2-1:0]   o_root,
    output logic      [SW-1:0]     o_side
);

    localparam int RTW = XW / 2;
    localparam int RW  = RTW + 3;

    logic [XW-1:0]  r_x  [0:RTW-1];
    logic [RW-1:0]  r_r  [0:RTW-1];
    logic [RTW-1:0] r_q  [0:RTW-1];
    logic [SW-1:0]  r_sd [0:RTW-1];

    for (genvar k = 0; k < RTW; k++) begin : g_stage
        logic [XW-1:0]  a_x;
        logic [RW-1:0]  a_r;
        logic [RTW-1:0] a_q;
        logic [SW-1:0]  a_sd;
        logic [RW-1:0]  w_rs;
        logic [RW-1:0]  w_t;
        logic [RW-1:0]  n_r;
        logic [RTW-1:0] n_q;

        if (k == 0) begin : g_first
            assign a_x  = i_x;
            assign a_r  = '0;
            assign a_q  = '0;
            assign a_sd = i_side;
        end else begin : g_next
            assign a_x  = r_x[k-1];
            assign a_r  = r_r[k-1];
            assign a_q  = r_q[k-1];
            assign a_sd = r_sd[k-1];
        end

        // bring down the next bit pair and try (root*4 + 1)
        assign w_rs = {a_r[RW-3:0], a_x[XW-1-2*k -: 2]};
        assign w_t  = {{(RW-RTW-2){1'b0}}, a_q, 2'b01};

        always_comb begin
            if (w_rs >= w_t) begin
                n_r = w_rs - w_t;
                n_q = {a_q[RTW-2:0], 1'b1};
            end else begin
                n_r = w_rs;
                n_q = {a_q[RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]  <= a_x;
                r_r[k]  <= n_r;
                r_q[k]  <= n_q;
                r_sd[k] <= a_sd;
            end
        end
    end

    assign o_root = r_q[RTW-1];
    assign o_side = r_sd[RTW-1];

endmodule

`default_nettype wire

@@ src/fnbc_div.sv @@
// fnbc_div: three-lane pipelined rounding divider, mag * 2^14 / len
// depends on: fnbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module fnbc_div #(
    parameter int MAG_W = fnbc_pkg::NORM_W,
    parameter int LEN_W = fnbc_pkg::NORM_W + 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [2:0][MAG_W-1:0]               i_mag,
    input  wire logic [LEN_W-1:0]                    i_len,
    input  wire fnbc_pkg::t_side                     i_side,
    output logic      [2:0][fnbc_pkg::QUO_W-1:0]     o_quo,
    output fnbc_pkg::t_side                          o_side
);

    localparam int QW = fnbc_pkg::QUO_W;
    localparam int NNW = MAG_W + fnbc_pkg::FRAC_W + 1;

    logic [2:0][LEN_W-1:0] r_rem [0:QW];
    logic [2:0][QW-1:0]    r_nlo [0:QW];
    logic [2:0][QW-1:0]    r_quo [0:QW];
    logic [LEN_W-1:0]      r_len [0:QW];
    fnbc_pkg::t_side       r_sd  [0:QW];

    logic [2:0][NNW-1:0]   w_num;

    // numerator with half the divisor added for round half up
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {i_mag[i], {fnbc_pkg::FRAC_W{1'b0}}} + NNW'(i_len >> 1);
        end
    end

    // quotient is below 2^15, so the top part is already below len
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= LEN_W'(w_num[i] >> QW);
                r_nlo[0][i] <= w_num[i][QW-1:0];
                r_quo[0][i] <= '0;
            end
            r_len[0] <= i_len;
            r_sd[0]  <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [2:0][LEN_W-1:0] n_rem;
        logic [2:0][QW-1:0]    n_quo;
        logic [LEN_W:0]        w_s [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_s[i] = {r_rem[k-1][i], r_nlo[k-1][i][QW-k]};
                if (w_s[i] >= {1'b0, r_len[k-1]}) begin
                    n_rem[i] = LEN_W'(w_s[i] - {1'b0, r_len[k-1]});
                    n_quo[i] = {r_quo[k-1][i][QW-2:0], 1'b1};
                end else begin
                    n_rem[i] = w_s[i][LEN_W-1:0];
                    n_quo[i] = {r_quo[k-1][i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_nlo[k] <= r_nlo[k-1];
                r_quo[k] <= n_quo;
                r_len[k] <= r_len[k-1];
                r_sd[k]  <= r_sd[k-1];
            end
        end
    end

    assign o_quo  = r_quo[QW];
    assign o_side = r_sd[QW];

endmodule

`default_nettype wire

@@ src/fnbc_checker.sv @@
// fnbc_checker: port-level assertions for face_normal_backface_cull_core
// depends on: fnbc_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module fnbc_checker #(
    parameter int COORD_WIDTH = fnbc_pkg::COORD_WIDTH_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic signed [COORD_WIDTH-1:0]     i_v0_x,
    input wire logic signed [COORD_WIDTH-1:0]     i_v0_y,
    input wire logic signed [COORD_WIDTH-1:0]     i_v0_z,
    input wire logic signed [COORD_WIDTH-1:0]     i_v1_x,
    input wire logic signed [COORD_WIDTH-1:0]     i_v1_y,
    input wire logic signed [COORD_WIDTH-1:0]     i_v1_z,
    input wire logic signed [COORD_WIDTH-1:0]     i_v2_x,
    input wire logic signed [COORD_WIDTH-1:0]     i_v2_y,
    input wire logic signed [COORD_WIDTH-1:0]     i_v2_z,
    input wire logic                              i_double_sided,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [fnbc_pkg::OUT_W-1:0] o_normal_x,
    input wire logic signed [fnbc_pkg::OUT_W-1:0] o_normal_y,
    input wire logic signed [fnbc_pkg::OUT_W-1:0] o_normal_z,
    input wire logic                              o_culled,
    input wire logic                              o_degenerate,
    input wire logic                              i_cfg_we,
    input wire logic [fnbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input wire logic [fnbc_pkg::EPS_W-1:0]        i_cfg_wdata
);

    localparam logic signed [fnbc_pkg::OUT_W-1:0] ONE  = 16384;
    localparam logic signed [fnbc_pkg::OUT_W-1:0] MONE = -16384;

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a degenerate face has a zero normal and is never culled
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            o_normal_x == 0 && o_normal_y == 0 && o_normal_z == 0 && !o_culled)
        else $error("degenerate face with non-zero normal or culled");

    // culled faces point away: z is negative
    a_culled_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_culled |-> o_normal_z < 0)
        else $error("culled face with non-negative normal z");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_normal_x <= ONE && o_normal_x >= MONE &&
            o_normal_y <= ONE && o_normal_y >= MONE &&
            o_normal_z <= ONE && o_normal_z >= MONE)
        else $error("normal component outside unit range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_normal_x) && $stable(o_normal_y) &&
            $stable(o_normal_z) && $stable(o_culled) && $stable(o_degenerate))
        else $error("stalled transaction changed");

endmodule

bind face_normal_backface_cull_core fnbc_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_fnbc_checker (.*);

`default_nettype wire

@@ bench/face_normal_backface_cull_core_tb.sv @@
// face_normal_backface_cull_core_tb: self-checking bench for the face normal / cull core
// depends on: fnbc_pkg, face_normal_backface_cull_core
`timescale 1ns / 1ps

module face_normal_backface_cull_core_tb;

    localparam int CW        = fnbc_pkg::COORD_WIDTH_DEF;
    localparam int LATENCY   = 57;
    localparam int WDOG_MAX  = 4000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic signed [fnbc_pkg::OUT_W-1:0] nx;
        logic signed [fnbc_pkg::OUT_W-1:0] ny;
        logic signed [fnbc_pkg::OUT_W-1:0] nz;
        logic                              culled;
        logic                              degen;
    } t_normal;

    // scoreboard: predicts the unit normal and cull flag, checks results in order
    class normal_scoreboard;
        t_normal    pending[$];
        bit         cull_en;
        logic [14:0] cull_eps;
        int         errors;
        int         n_checked;
        int         n_culled;
        int         n_degen;

        function void set_defaults();
            cull_en  = 1'b1;
            cull_eps = 15'd1;
        endfunction

        function longint unsigned root64(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_face(t_coord v[9], bit dbl);
            longint d1[3];
            longint d2[3];
            longint cr[3];
            longint unsigned mg[3];
            bit ng[3];
            longint unsigned mx;
            longint unsigned sum;
            longint unsigned len;
            longint unsigned q;
            longint nv[3];
            int blen;
            t_normal r;
            for (int i = 0; i < 3; i++) begin
                d1[i] = longint'(v[3+i]) - longint'(v[i]);
                d2[i] = longint'(v[6+i]) - longint'(v[3+i]);
            end
            cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
            cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
            cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                ng[i] = cr[i] < 0;
                mg[i] = ng[i] ? longint'(-cr[i]) : longint'(cr[i]);
                if (mg[i] > mx) mx = mg[i];
            end
            r = '0;
            if (mx == 0) begin
                r.degen = 1'b1;
            end else begin
                blen = 0;
                for (int i = 0; i < 64; i++) if (mx[i]) blen = i + 1;
                sum = 0;
                for (int i = 0; i < 3; i++) begin
                    if (blen <= fnbc_pkg::NORM_W) mg[i] = mg[i] << (fnbc_pkg::NORM_W - blen);
                    else mg[i] = mg[i] >> (blen - fnbc_pkg::NORM_W);
                    sum += mg[i] * mg[i];
                end
                len = root64(sum);
                for (int i = 0; i < 3; i++) begin
                    q = (mg[i] * (64'd1 << fnbc_pkg::FRAC_W) + (len >> 1)) / len;
                    nv[i] = ng[i] ? -longint'(q) : longint'(q);
                end
                r.nx = nv[0][fnbc_pkg::OUT_W-1:0];
                r.ny = nv[1][fnbc_pkg::OUT_W-1:0];
                r.nz = nv[2][fnbc_pkg::OUT_W-1:0];
                r.culled = cull_en && !dbl && (nv[2] < -longint'(cull_eps));
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_normal got);
            t_normal exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            n_checked++;
            if (exp_r.culled) n_culled++;
            if (exp_r.degen) n_degen++;
            if (got.nx !== exp_r.nx) begin
                $error("normal_x exp %0d got %0d", exp_r.nx, got.nx); errors++;
            end
            if (got.ny !== exp_r.ny) begin
                $error("normal_y exp %0d got %0d", exp_r.ny, got.ny); errors++;
            end
            if (got.nz !== exp_r.nz) begin
                $error("normal_z exp %0d got %0d", exp_r.nz, got.nz); errors++;
            end
            if (got.culled !== exp_r.culled) begin
                $error("culled exp %0b got %0b", exp_r.culled, got.culled); errors++;
            end
            if (got.degen !== exp_r.degen) begin
                $error("degenerate exp %0b got %0b", exp_r.degen, got.degen); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_coord vin[9];
    logic i_double_sided = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [fnbc_pkg::OUT_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_culled, o_degenerate;
    logic i_cfg_we = 1'b0;
    logic [fnbc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [fnbc_pkg::EPS_W-1:0] i_cfg_wdata = '0;

    normal_scoreboard sb;
    int  idle_pct = 21;
    int  stall_cycles = 0;
    bit  timed_out = 1'b0;

    initial for (int i = 0; i < 9; i++) vin[i] = '0;

    always #5 i_clk = ~i_clk;

    face_normal_backface_cull_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_v0_x(vin[0]), .i_v0_y(vin[1]), .i_v0_z(vin[2]),
        .i_v1_x(vin[3]), .i_v1_y(vin[4]), .i_v1_z(vin[5]),
        .i_v2_x(vin[6]), .i_v2_y(vin[7]), .i_v2_z(vin[8]),
        .i_double_sided(i_double_sided),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_culled(o_culled), .o_degenerate(o_degenerate),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    initial sb = new();

    // result side: sample at the rising edge, change ready at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result({o_normal_x, o_normal_y, o_normal_z, o_culled, o_degenerate});
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99, 0) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [fnbc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[fnbc_pkg::EPS_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == fnbc_pkg::CFG_CULL_ENABLE) sb.cull_en = val[0];
        else sb.cull_eps = val[fnbc_pkg::EPS_W-1:0];
    endtask

    // present one face, hold it until accepted; called at a falling edge
    task automatic send_face(t_coord v[9], bit dbl);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++) vin[i] <= v[i];
        i_double_sided <= dbl;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_face(v, dbl);
        @(negedge i_clk);
    endtask

    // called at a falling edge, right after the last transaction was taken
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    function automatic t_coord rnd_coord(int sel);
        case (sel)
            0: return t_coord'($urandom_range(65535, 0));
            1: return t_coord'($signed($urandom_range(64, 0)) - 32);
            default: return t_coord'($signed($urandom_range(4096, 0)) - 2048);
        endcase
    endfunction

    task automatic random_faces(int count, int sel_max);
        t_coord v[9];
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(sel_max, 0);
            for (int i = 0; i < 9; i++) v[i] = rnd_coord(sel);
            // occasionally collapse the triangle
            if ($urandom_range(15, 0) == 0) v[6] = v[3];
            if ($urandom_range(31, 0) == 0) begin v[3] = v[0]; v[4] = v[1]; v[5] = v[2]; end
            send_face(v, $urandom_range(1, 0));
        end
    endtask

    task automatic directed_faces();
        t_coord v[9];
        t_coord mx = {1'b0, {(CW-1){1'b1}}};
        t_coord mn = {1'b1, {(CW-1){1'b0}}};
        // front facing and back facing unit triangles
        v = '{0, 0, 0, 16384, 0, 0, 0, 16384, 0};
        send_face(v, 0); send_face(v, 1);
        v = '{0, 0, 0, 0, 16384, 0, 16384, 0, 0};
        send_face(v, 0); send_face(v, 1);
        // zero-length cross product: coincident and collinear points
        v = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
        send_face(v, 0);
        v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
        send_face(v, 0);
        // extremes of the coordinate range
        v = '{mn, mn, mn, mx, mn, mx, mn, mx, mx};
        send_face(v, 0);
        v = '{mx, mx, mx, mn, mx, mn, mx, mn, mn};
        send_face(v, 1);
        v = '{mx, mn, 0, mn, mx, mn, mx, mx, mn};
        send_face(v, 0);
        v = '{-1, -1, -1, mx, mx, mx, mn, mn, mn};
        send_face(v, 0);
        // tiny faces, normal almost on the z axis and nearly edge-on
        v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
        send_face(v, 0);
        v = '{0, 0, 0, 1000, 0, 1, 0, 1000, 0};
        send_face(v, 0);
        v = '{0, 0, 0, 1000, 0, 0, 0, 0, 1000};
        send_face(v, 0);
        v = '{0, 0, 0, 1000, 0, -2, 0, 1000, 0};
        send_face(v, 0);
    endtask

    initial begin
        sb.set_defaults();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings first
        directed_faces();
        drain();
        write_reg(fnbc_pkg::CFG_CULL_EPSILON, 0);
        directed_faces();
        random_faces(150, 2);
        drain();
        write_reg(fnbc_pkg::CFG_CULL_ENABLE, 0);
        write_reg(fnbc_pkg::CFG_CULL_EPSILON, 32767);
        random_faces(150, 2);
        drain();
        write_reg(fnbc_pkg::CFG_CULL_ENABLE, 1);
        random_faces(150, 2);
        drain();
        write_reg(fnbc_pkg::CFG_CULL_EPSILON, 16384);
        random_faces(100, 2);
        drain();
        write_reg(fnbc_pkg::CFG_CULL_EPSILON, 16383);
        random_faces(100, 2);
        drain();
        write_reg(fnbc_pkg::CFG_CULL_EPSILON, $urandom_range(8000, 0));
        // full-rate stretch with no idling on either side
        idle_pct = 0;
        random_faces(250, 2);
        idle_pct = 21;
        drain();
        write_reg(fnbc_pkg::CFG_CULL_EPSILON, 1);
        random_faces(200, 2);
        drain();

        $display("checked %0d faces: %0d culled, %0d degenerate, several cull settings",
                 sb.n_checked, sb.n_culled, sb.n_degen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
